### sv/alm_pkg.sv
package alm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W = 17;
  localparam int SUM_W = 28;
  localparam int REG_W = 10;
  localparam int LEN_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int FULL_SCALE_SHIFT = 15;
  localparam int NUM_W = SUM_W + REG_W;
  localparam int QUO_W = REG_W + 1;
  localparam int STEP_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CEILING = 2'd1;
  localparam logic [REG_W-1:0] GAIN_RESET = 10'd500;
  localparam logic [REG_W-1:0] CEILING_RESET = 10'd100;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctrl_t;

endpackage

### sv/alm_front.sv
module alm_front #(
  parameter int MAX_BLOCK_SAMPLES = 4096,
  parameter int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1),
  parameter int ENTRY_W = alm_pkg::SUM_W + CNT_W + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                last_sample,
  output logic                                push,
  output logic [ENTRY_W-1:0]                  push_data
);

  logic [alm_pkg::SUM_W-1:0] magnitude_sum;
  logic [CNT_W-1:0]          sample_count;
  logic                      overflow_seen;

  logic [alm_pkg::SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]          count_next;
  logic                      over_next;
  logic [alm_pkg::MAG_W-1:0] ext;
  logic [alm_pkg::MAG_W-1:0] mag;
  logic [alm_pkg::SUM_W:0]   sum_wide;

  always_comb begin
    ext = {sample_value[alm_pkg::SAMPLE_W-1], sample_value};
    mag = ext[alm_pkg::MAG_W-1] ? (~ext + alm_pkg::MAG_W'(1)) : ext;
    sum_wide = {1'b0, magnitude_sum} + (alm_pkg::SUM_W+1)'(mag);
    sum_next = magnitude_sum;
    count_next = sample_count;
    over_next = overflow_seen;
    if (sample_count < CNT_W'(MAX_BLOCK_SAMPLES)) begin
      count_next = sample_count + CNT_W'(1);
      sum_next = sum_wide[alm_pkg::SUM_W] ? {alm_pkg::SUM_W{1'b1}}
                                          : sum_wide[alm_pkg::SUM_W-1:0];
    end else begin
      over_next = 1'b1;
    end
    push = accept && last_sample;
    push_data = {sum_next, count_next, over_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_sum <= '0;
      sample_count <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last_sample) begin
        magnitude_sum <= '0;
        sample_count <= '0;
        overflow_seen <= 1'b0;
      end else begin
        magnitude_sum <= sum_next;
        sample_count <= count_next;
        overflow_seen <= over_next;
      end
    end
  end

endmodule

### sv/alm_queue.sv
module alm_queue #(
  parameter int ENTRY_W = 46
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [ENTRY_W-1:0] push_data,
  input  logic               pop,
  output logic [ENTRY_W-1:0] pop_data,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = $clog2(alm_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(alm_pkg::QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] entries [alm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full = (fill == FILL_W'(alm_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Closed block pushed into a full queue.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Queue popped while empty.");

endmodule

### sv/alm_back.sv
module alm_back #(
  parameter int MAX_BLOCK_SAMPLES = 4096,
  parameter int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1),
  parameter int ENTRY_W = alm_pkg::SUM_W + CNT_W + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [alm_pkg::REG_W-1:0]  level_gain,
  input  logic [alm_pkg::REG_W-1:0]  level_ceiling,
  input  logic                       queue_empty,
  input  logic [ENTRY_W-1:0]         queue_data,
  output logic                       pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [alm_pkg::REG_W-1:0]  level,
  output logic [alm_pkg::LEN_W-1:0]  block_length,
  output logic                       overlong
);

  localparam int DEN_W = CNT_W + alm_pkg::FULL_SCALE_SHIFT;
  localparam int DIV_W = DEN_W + alm_pkg::REG_W;
  localparam int AW = (DIV_W > alm_pkg::NUM_W) ? DIV_W : alm_pkg::NUM_W;

  alm_pkg::back_state_t state;
  alm_pkg::back_state_t state_next;

  logic [AW-1:0]                  rem;
  logic [AW-1:0]                  divisor;
  logic [alm_pkg::QUO_W-1:0]      quo;
  logic [alm_pkg::STEP_W-1:0]     step;
  logic [CNT_W-1:0]               count_q;
  logic                           over_q;

  logic [alm_pkg::SUM_W-1:0]      q_sum;
  logic [CNT_W-1:0]               q_count;
  logic                           q_over;
  logic [alm_pkg::NUM_W-1:0]      product;
  logic [DEN_W-1:0]               den;
  logic                           ge;
  logic                           load_out;
  logic [alm_pkg::REG_W-1:0]      level_next;

  always_comb begin
    {q_sum, q_count, q_over} = queue_data;
    product = alm_pkg::NUM_W'(q_sum) * alm_pkg::NUM_W'(level_gain);
    den = {q_count, {alm_pkg::FULL_SCALE_SHIFT{1'b0}}} - DEN_W'(q_count);
    ge = (rem >= divisor);
    if (quo[alm_pkg::QUO_W-1] || (quo[alm_pkg::REG_W-1:0] > level_ceiling)) begin
      level_next = level_ceiling;
    end else begin
      level_next = quo[alm_pkg::REG_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    load_out = 1'b0;
    unique case (state)
      alm_pkg::BK_IDLE: begin
        if (!queue_empty) begin
          pop = 1'b1;
          state_next = alm_pkg::BK_DIV;
        end
      end
      alm_pkg::BK_DIV: begin
        if (step == '0) begin
          state_next = alm_pkg::BK_DONE;
        end
      end
      alm_pkg::BK_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out = 1'b1;
          state_next = alm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = alm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem <= AW'(product);
      divisor <= AW'(den) << alm_pkg::REG_W;
      quo <= '0;
      step <= alm_pkg::STEP_W'(alm_pkg::REG_W);
      count_q <= q_count;
      over_q <= q_over;
    end else if (state == alm_pkg::BK_DIV) begin
      if (ge) begin
        rem <= rem - divisor;
      end
      divisor <= divisor >> 1;
      quo <= {quo[alm_pkg::QUO_W-2:0], ge};
      step <= step - alm_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      level <= level_next;
      block_length <= alm_pkg::LEN_W'(count_q);
      overlong <= over_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_level_within_ceiling: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= level_ceiling)
    else $error("Reported level exceeds the ceiling.");

  a_overlong_full_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overlong) |-> block_length == alm_pkg::LEN_W'(MAX_BLOCK_SAMPLES))
    else $error("Overlong block does not report the maximum length.");

endmodule

### sv/block_audio_level_meter_unit.sv
// Mean absolute level meter: signed 16-bit samples are accepted one per cycle and summed as
// magnitudes until a sample marked last_sample closes the block; each block then yields one
// request with level = min(floor(sum * level_gain / (count * 32767)), level_ceiling), the
// block length and an overlong flag. The closing step runs in a shared restoring divider
// that loads the product, takes eleven quotient steps and then loads the output registers,
// and a two-entry queue of closed blocks sits in front of it, so the input stalls only
// when that queue is full: when short blocks arrive back to back faster than the divider
// finishes them or when results are held back at the output.
module block_audio_level_meter_unit #(
  parameter int MAX_BLOCK_SAMPLES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [alm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [alm_pkg::REG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [alm_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [alm_pkg::REG_W-1:0]           level,
  output logic [alm_pkg::LEN_W-1:0]           block_length,
  output logic                                overlong
);

  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int ENTRY_W = alm_pkg::SUM_W + CNT_W + 1;

  logic [alm_pkg::REG_W-1:0] level_gain;
  logic [alm_pkg::REG_W-1:0] level_ceiling;
  alm_pkg::queue_ctrl_t      qc;
  logic [ENTRY_W-1:0]        push_data;
  logic [ENTRY_W-1:0]        pop_data;
  logic                      accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_gain <= alm_pkg::GAIN_RESET;
      level_ceiling <= alm_pkg::CEILING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        alm_pkg::REG_LEVEL_GAIN:    level_gain <= cfg_data;
        alm_pkg::REG_LEVEL_CEILING: level_ceiling <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = qc.full;
  assign accept = in_valid && !in_stall;

  alm_front #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES),
    .CNT_W(CNT_W),
    .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .sample_value(sample_value),
    .last_sample(last_sample),
    .push(qc.push),
    .push_data(push_data)
  );

  alm_queue #(
    .ENTRY_W(ENTRY_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(qc.push),
    .push_data(push_data),
    .pop(qc.pop),
    .pop_data(pop_data),
    .full(qc.full),
    .empty(qc.empty)
  );

  alm_back #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES),
    .CNT_W(CNT_W),
    .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .level_gain(level_gain),
    .level_ceiling(level_ceiling),
    .queue_empty(qc.empty),
    .queue_data(pop_data),
    .pop(qc.pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .level(level),
    .block_length(block_length),
    .overlong(overlong)
  );

endmodule
